### hw/rtl/mte_pkg.sv
package mte_pkg;

    localparam int SAMPLE_W = 20;
    localparam int WEIGHT_W = 9;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd26;

    // one classified sample on its way to the averaging stage
    typedef struct packed {
        logic                full;
        logic [SAMPLE_W-1:0] median;
    } mte_entry_t;

    // queue occupancy seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } mte_qstat_t;

endpackage

### hw/rtl/mte_front.sv
module mte_front #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mte_pkg::SAMPLE_W-1:0] s_sample,
    output logic                         push_valid,
    input  logic                         push_ready,
    output mte_pkg::mte_entry_t          push_entry
);

    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int RANK_W = $clog2(WINDOW_SIZE);
    localparam int MID    = WINDOW_SIZE / 2;

    logic [mte_pkg::SAMPLE_W-1:0] win_reg [WINDOW_SIZE];
    logic [CNT_W-1:0]             fill_cnt_reg, fill_cnt_next;
    logic                         stage_valid_reg, stage_valid_next;
    logic                         stage_full_reg;
    logic [mte_pkg::SAMPLE_W-1:0] stage_sample_reg;
    logic [RANK_W-1:0]            rank [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0]       is_mid;
    logic [mte_pkg::SAMPLE_W-1:0] median_sel;
    logic                         s_fire;

    assign s_tready = !stage_valid_reg || push_ready;
    assign s_fire   = s_tvalid && s_tready;

    // control state: fill count and stage occupancy
    always_comb begin
        fill_cnt_next = fill_cnt_reg;
        if (s_fire && fill_cnt_reg != CNT_W'(WINDOW_SIZE)) begin
            fill_cnt_next = fill_cnt_reg + CNT_W'(1);
        end
        stage_valid_next = stage_valid_reg;
        if (s_fire) begin
            stage_valid_next = 1'b1;
        end else if (push_ready) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg    <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            fill_cnt_reg    <= fill_cnt_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // sample shift line and stage payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            win_reg[0] <= s_sample;
            for (int k = 1; k < WINDOW_SIZE; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
            stage_sample_reg <= s_sample;
            stage_full_reg   <= (fill_cnt_reg >= CNT_W'(WINDOW_SIZE - 1));
        end
    end

    // rank of each tap, ties broken by tap position
    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                if (j != i) begin
                    if (win_reg[j] < win_reg[i] || (win_reg[j] == win_reg[i] && j < i)) begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
            is_mid[i] = (rank[i] == RANK_W'(MID));
        end
    end

    // one-hot select of the middle-ranked tap
    always_comb begin
        median_sel = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            median_sel = median_sel | (win_reg[i] & {mte_pkg::SAMPLE_W{is_mid[i]}});
        end
    end

    assign push_valid        = stage_valid_reg;
    assign push_entry.full   = stage_full_reg;
    assign push_entry.median = stage_full_reg ? median_sel : stage_sample_reg;

endmodule

### hw/rtl/mte_queue.sv
module mte_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  mte_pkg::mte_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mte_pkg::mte_entry_t pop_entry,
    output mte_pkg::mte_qstat_t qstat
);

    mte_pkg::mte_entry_t mem_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                push_fire, pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign qstat.full  = !push_ready;
    assign qstat.empty = !pop_valid;

    // pointer and count update
    always_comb begin
        wr_ptr_next = push_fire ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 2'd1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/mte_back.sv
module mte_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  mte_pkg::mte_entry_t          pop_entry,
    input  logic [mte_pkg::WEIGHT_W-1:0] weight,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mte_pkg::SAMPLE_W-1:0] m_median,
    output logic [mte_pkg::SAMPLE_W-1:0] m_smoothed,
    output logic                         m_full
);

    logic                         m_valid_reg, m_valid_next;
    logic [mte_pkg::SAMPLE_W-1:0] m_median_reg;
    logic                         m_full_reg;
    logic [mte_pkg::SAMPLE_W-1:0] avg_reg, avg_next;
    logic                         avg_valid_reg, avg_valid_next;
    logic [mte_pkg::WEIGHT_W-1:0] w_eff;
    logic signed [mte_pkg::SAMPLE_W:0]    diff;
    logic signed [mte_pkg::WEIGHT_W:0]    w_s;
    logic signed [mte_pkg::SAMPLE_W+mte_pkg::WEIGHT_W+1:0] prod;
    logic signed [mte_pkg::SAMPLE_W+mte_pkg::WEIGHT_W+1:0] prod_sh;
    logic [mte_pkg::SAMPLE_W:0]   sum;
    logic                         pop_fire;

    assign pop_ready = !m_valid_reg || m_ready;
    assign pop_fire  = pop_valid && pop_ready;

    // weights of 256 and above all mean follow the median
    assign w_eff = weight[mte_pkg::WEIGHT_W-1] ? mte_pkg::WEIGHT_FULL : weight;

    // avg + ((median - avg) * w) >>> 8 equals the floored weighted sum
    always_comb begin
        diff    = $signed({1'b0, pop_entry.median}) - $signed({1'b0, avg_reg});
        w_s     = $signed({1'b0, w_eff});
        prod    = diff * w_s;
        prod_sh = prod >>> 8;
        sum     = {1'b0, avg_reg} + prod_sh[mte_pkg::SAMPLE_W:0];
    end

    // average and output register control
    always_comb begin
        avg_next       = avg_reg;
        avg_valid_next = avg_valid_reg;
        m_valid_next   = m_valid_reg;
        if (pop_fire) begin
            avg_next       = avg_valid_reg ? sum[mte_pkg::SAMPLE_W-1:0] : pop_entry.median;
            avg_valid_next = 1'b1;
            m_valid_next   = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg       <= '0;
            avg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            avg_reg       <= avg_next;
            avg_valid_reg <= avg_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            m_median_reg <= pop_entry.median;
            m_full_reg   <= pop_entry.full;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_median   = m_median_reg;
    assign m_smoothed = avg_reg;
    assign m_full     = m_full_reg;

endmodule

### hw/rtl/median_then_ema_smoother.sv
// path: input transfer to result valid passes the window stage, the queue and the output register
// throughput: one transfer per cycle unless m_tready stalls the output; the median rank network over
//   the sample window and the single-multiply average update are both combinational
// reset: synchronous active low; clears fill count, average, queue and output valid, weight to 26;
//   sample window contents are not cleared and are read only once fully written
module median_then_ema_smoother #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,   // smoothing_weight
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [19:0] sample, [23:20] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // [19:0] median_value, [39:20] smoothed_value
    output logic        m_tuser        // [0] window_full
);

    logic [mte_pkg::WEIGHT_W-1:0] weight_reg;
    logic                         push_valid, push_ready;
    mte_pkg::mte_entry_t          push_entry, pop_entry;
    logic                         pop_valid, pop_ready;
    mte_pkg::mte_qstat_t          qstat;
    logic [mte_pkg::SAMPLE_W-1:0] m_median, m_smoothed;

    // weight register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= mte_pkg::WEIGHT_RESET;
        end else if (cfg_wr_en) begin
            weight_reg <= cfg_wr_data;
        end
    end

    mte_front #(.WINDOW_SIZE(WINDOW_SIZE)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_sample   (s_tdata[mte_pkg::SAMPLE_W-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    mte_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    mte_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .weight     (weight_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_median   (m_median),
        .m_smoothed (m_smoothed),
        .m_full     (m_tuser)
    );

    assign m_tdata = {m_smoothed, m_median};

    // queue is never reported full and empty at once
    a_qstat_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty together");

    // an accepted sample occupies the window stage in the next cycle
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> push_valid)
        else $error("accepted sample lost in front stage");

    // a stalled result is never overwritten by a queue pop
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(pop_valid && pop_ready))
        else $error("result register overwritten while stalled");

endmodule

### tb/median_ema_checker.sv
module median_ema_checker #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [mte_pkg::WEIGHT_W-1:0] cfg_wr_data,   // smoothing_weight
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [23:0]                  s_tdata,       // [19:0] sample, [23:20] zero
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [39:0]                  m_tdata,       // [19:0] median_value, [39:20] smoothed_value
    input  logic                         m_tuser,       // [0] window_full
    output int                           mismatch_count,
    output int                           results_in_flight
);

    // one predicted output transfer
    typedef struct packed {
        logic                         full;
        logic [mte_pkg::SAMPLE_W-1:0] smoothed;
        logic [mte_pkg::SAMPLE_W-1:0] median;
    } smoothed_out_t;

    // shadow copy of the filter state
    logic [mte_pkg::SAMPLE_W-1:0] ring [WINDOW_SIZE];
    int                           ring_slot;
    logic                         ring_filled;
    logic [mte_pkg::SAMPLE_W-1:0] average;
    logic                         average_loaded;
    logic [mte_pkg::WEIGHT_W-1:0] weight;

    smoothed_out_t                smoothed_q [$];
    int                           fail_total;

    initial begin
        fail_total = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, predicted %0d", $time, what, got, want);
        fail_total++;
    endtask

    // middle of the sorted ring, upper middle for an even size
    function automatic logic [mte_pkg::SAMPLE_W-1:0] ring_median();
        logic [mte_pkg::SAMPLE_W-1:0] sorted [WINDOW_SIZE];
        logic [mte_pkg::SAMPLE_W-1:0] held;
        int i;
        int j;
        sorted = ring;
        for (i = 1; i < WINDOW_SIZE; i++) begin
            held = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > held) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = held;
        end
        return sorted[WINDOW_SIZE / 2];
    endfunction

    // advance the filter by one sample and queue the output it produces
    task automatic filter_sample(input logic [mte_pkg::SAMPLE_W-1:0] sample);
        smoothed_out_t                next_out;
        logic [mte_pkg::SAMPLE_W-1:0] median;
        logic [mte_pkg::WEIGHT_W-1:0] eff_weight;
        logic [mte_pkg::WEIGHT_W-1:0] keep_weight;
        logic [39:0]                  weighted_sum;
        ring[ring_slot] = sample;
        ring_slot = (ring_slot == WINDOW_SIZE - 1) ? 0 : ring_slot + 1;
        if (!ring_filled && ring_slot == 0) begin
            ring_filled = 1'b1;
        end
        median = ring_filled ? ring_median() : sample;

        // weights past full scale saturate
        eff_weight = (weight > mte_pkg::WEIGHT_FULL) ? mte_pkg::WEIGHT_FULL : weight;
        keep_weight = mte_pkg::WEIGHT_FULL - eff_weight;
        if (average_loaded) begin
            weighted_sum = 40'(average) * 40'(keep_weight) + 40'(median) * 40'(eff_weight);
            average = weighted_sum[mte_pkg::SAMPLE_W+7:8];
        end else begin
            average = median;
            average_loaded = 1'b1;
        end

        next_out.full = ring_filled;
        next_out.smoothed = average;
        next_out.median = median;
        smoothed_q.push_back(next_out);
    endtask

    task automatic compare_result(input smoothed_out_t got);
        smoothed_out_t want;
        if (smoothed_q.size() == 0) begin
            report_mismatch("output transfer with nothing pending", got.median, 0);
            return;
        end
        want = smoothed_q.pop_front();
        if (got.median !== want.median) begin
            report_mismatch("median_value", got.median, want.median);
        end
        if (got.smoothed !== want.smoothed) begin
            report_mismatch("smoothed_value", got.smoothed, want.smoothed);
        end
        if (got.full !== want.full) begin
            report_mismatch("window_full", got.full, want.full);
        end
    endtask

    // watch config writes and both channels at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            ring_slot = 0;
            ring_filled = 1'b0;
            average = '0;
            average_loaded = 1'b0;
            weight = mte_pkg::WEIGHT_RESET;
            smoothed_q.delete();
        end else begin
            if (cfg_wr_en) begin
                weight = cfg_wr_data;
            end
            // results first, a sample cannot come out on its own edge
            if (m_tvalid && m_tready) begin
                compare_result({m_tuser, m_tdata[39:20], m_tdata[19:0]});
            end
            if (s_tvalid && s_tready) begin
                filter_sample(s_tdata[mte_pkg::SAMPLE_W-1:0]);
            end
        end
        mismatch_count <= fail_total;
        results_in_flight <= smoothed_q.size();
    end

endmodule

### tb/median_then_ema_smoother_test.sv
module median_then_ema_smoother_test;

    localparam int WINDOW = 5;
    localparam logic [mte_pkg::SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam int RANDOM_BLOCKS = 4;
    localparam int PER_BLOCK = 104;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES = 24;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT = 880;
    localparam int HOLD_CYCLES = 150;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [mte_pkg::WEIGHT_W-1:0] cfg_wr_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [23:0]                  s_tdata;   // [19:0] sample, [23:20] zero
    logic                         m_tvalid;
    logic                         m_tready;
    logic [39:0]                  m_tdata;   // [19:0] median_value, [39:20] smoothed_value
    logic                         m_tuser;   // [0] window_full

    int mismatch_count;
    int results_in_flight;
    int samples_sent;
    int sender_idle_pct;
    int receiver_idle_pct;
    int quiet_cycles;
    logic hold_done;

    median_then_ema_smoother #(
        .WINDOW_SIZE(WINDOW)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    median_ema_checker #(
        .WINDOW_SIZE(WINDOW)
    ) checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .mismatch_count(mismatch_count),
        .results_in_flight(results_in_flight)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever begin
            #4 aclk = ~aclk;
        end
    end

    // count accepted samples, used to place the long output stall
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            samples_sent <= samples_sent + 1;
        end
    end

    // offer one sample, with random idle cycles ahead of it
    task automatic send_sample(input logic [mte_pkg::SAMPLE_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, value};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // let the pipeline empty, then load a new weight
    task automatic write_weight(input logic [mte_pkg::WEIGHT_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_in_flight != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // output side: random back-pressure plus one long hold-off
    initial begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && samples_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int base;
        int value;
        int last;
        int mode;
        int blk;
        logic [mte_pkg::WEIGHT_W-1:0] weight;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset weight: passthrough until the ring fills, then ties and extremes
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(20'h00001);
        send_sample(20'h80000);
        send_sample(SAMPLE_MAX);
        send_sample(20'h55555);
        send_sample(20'hAAAAA);
        send_sample('0);

        // zero weight holds the average
        write_weight(9'd0);
        send_sample(20'h01234);
        send_sample(SAMPLE_MAX);
        send_sample('0);

        // weights above full scale saturate
        write_weight(9'd511);
        send_sample(20'h00007);
        send_sample(20'h00009);
        send_sample(SAMPLE_MAX);
        write_weight(9'd257);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        write_weight(mte_pkg::WEIGHT_FULL);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);

        // smallest weight with the average at full range
        write_weight(9'd1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        write_weight(9'd255);
        send_sample('0);
        send_sample(20'h00010);

        // random part: three idle profiles, several weights in each
        last = 0;
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    sender_idle_pct = 18;
                    receiver_idle_pct = 51;
                end
                1: begin
                    sender_idle_pct = 51;
                    receiver_idle_pct = 18;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
                case ($urandom_range(7))
                    0: weight = 9'd0;
                    1: weight = 9'd1;
                    2: weight = 9'd255;
                    3: weight = mte_pkg::WEIGHT_FULL;
                    4: weight = 9'd257;
                    5: weight = 9'd511;
                    6: weight = mte_pkg::WEIGHT_W'($urandom_range(511));
                    default: weight = mte_pkg::WEIGHT_W'($urandom_range(256, 1));
                endcase
                write_weight(weight);
                base = $urandom_range(int'(SAMPLE_MAX));
                repeat (PER_BLOCK) begin
                    // mostly a noisy steady distance, with spikes and extremes
                    case ($urandom_range(9))
                        0, 1, 2, 3: value = base + $urandom_range(512) - 256;
                        4, 5: value = $urandom_range(int'(SAMPLE_MAX));
                        6: value = $urandom_range(1) ? int'(SAMPLE_MAX) : 0;
                        7: value = last;
                        default: value = base + $urandom_range(65536) - 32768;
                    endcase
                    if (value < 0) begin
                        value = 0;
                    end else if (value > int'(SAMPLE_MAX)) begin
                        value = int'(SAMPLE_MAX);
                    end
                    last = value;
                    send_sample(mte_pkg::SAMPLE_W'(value));
                end
            end
        end

        // drain and give the verdict
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_in_flight != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_in_flight == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/mte_pkg.sv
hw/rtl/mte_front.sv
hw/rtl/mte_queue.sv
hw/rtl/mte_back.sv
hw/rtl/median_then_ema_smoother.sv
tb/median_ema_checker.sv
tb/median_then_ema_smoother_test.sv
